>>> src/spbp_pkg.sv
// Shared types and constants for the schedule program blob parser.
package spbp_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PROG_W   = 8;
  localparam int unsigned TIMER_W  = 9;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned STATE_W  = 3;
  localparam int unsigned HOUR_W   = 6;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned OFFS_W   = 18;
  localparam int unsigned CODE_W   = 5;
  localparam int unsigned MINS_W   = 11;

  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 56;
  localparam int unsigned M_TUSER_W = 2;

  // Timer word low five bits
  localparam logic [CODE_W-1:0] CODE_CLOCK_OFF = 5'd1;
  localparam logic [CODE_W-1:0] CODE_SUN_OFF   = 5'd3;
  localparam logic [CODE_W-1:0] CODE_CLOCK_ON  = 5'd5;
  localparam logic [CODE_W-1:0] CODE_SUN_ON    = 5'd7;

  localparam logic [10:0] RECIP_60     = 11'd1092;
  localparam logic [5:0]  SECS_PER_MIN = 6'd60;

  typedef struct packed {
    logic [PROG_W-1:0]  program_index;
    logic [TIMER_W-1:0] timer_index;
    logic [WORD_W-1:0]  word;
    logic               blob_done;
  } word_item_t;

  typedef struct packed {
    logic [PROG_W-1:0]  program_index;
    logic [TIMER_W-1:0] timer_index;
    logic [STATE_W-1:0] switch_state;
    logic               event_kind;
    logic               recognized;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic               sun_reference;
    logic [OFFS_W-1:0]  offset_seconds;
    logic               blob_done;
  } result_t;

endpackage

>>> src/spbp_front.sv
// Byte-level blob walker: tracks header, count and timer words, pushes timer words.
module spbp_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [7:0]              data_byte_i,
  input  logic                    first_byte_i,
  output logic                    push_o,
  output spbp_pkg::word_item_t    push_item_o
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_CNT_LO = 3'd2;
  localparam logic [2:0] PH_CNT_HI = 3'd3;
  localparam logic [2:0] PH_TMR_LO = 3'd4;
  localparam logic [2:0] PH_TMR_HI = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  logic [2:0] phase_q, phase_d;
  logic [2:0] hdr_pos_q, hdr_pos_d;
  logic [7:0] progs_left_q, progs_left_d;
  logic [7:0] cur_prog_q, cur_prog_d;
  logic [8:0] timers_left_q, timers_left_d;
  logic [8:0] cur_timer_q, cur_timer_d;
  logic [7:0] low_byte_q, low_byte_d;
  logic [7:0] progs_after;
  logic [8:0] count_val;
  logic       accept;

  assign accept      = in_valid_i && in_ready_i;
  assign progs_after = progs_left_q - 8'd1;
  assign count_val   = {data_byte_i, low_byte_q[7]};

  always_comb begin
    phase_d       = phase_q;
    hdr_pos_d     = hdr_pos_q;
    progs_left_d  = progs_left_q;
    cur_prog_d    = cur_prog_q;
    timers_left_d = timers_left_q;
    cur_timer_d   = cur_timer_q;
    low_byte_d    = low_byte_q;
    if (accept) begin
      if (first_byte_i) begin
        phase_d       = PH_HEADER;
        hdr_pos_d     = 3'd1;
        progs_left_d  = '0;
        cur_prog_d    = '0;
        timers_left_d = '0;
        cur_timer_d   = '0;
        low_byte_d    = '0;
      end else begin
        case (phase_q)
          PH_HEADER: begin
            if (hdr_pos_q == 3'd1) begin
              progs_left_d = data_byte_i - 8'd1;
            end
            if (hdr_pos_q >= 3'd6) begin
              hdr_pos_d = '0;
              phase_d   = (progs_left_q == 8'd0) ? PH_DONE : PH_CNT_LO;
            end else begin
              hdr_pos_d = hdr_pos_q + 3'd1;
            end
          end
          PH_CNT_LO: begin
            low_byte_d = data_byte_i;
            phase_d    = PH_CNT_HI;
          end
          PH_CNT_HI: begin
            timers_left_d = count_val;
            cur_timer_d   = '0;
            if (count_val == 9'd0) begin
              progs_left_d = progs_after;
              cur_prog_d   = cur_prog_q + 8'd1;
              phase_d      = (progs_after == 8'd0) ? PH_DONE : PH_CNT_LO;
            end else begin
              phase_d = PH_TMR_LO;
            end
          end
          PH_TMR_LO: begin
            low_byte_d = data_byte_i;
            phase_d    = PH_TMR_HI;
          end
          PH_TMR_HI: begin
            cur_timer_d   = cur_timer_q + 9'd1;
            timers_left_d = timers_left_q - 9'd1;
            if (timers_left_q == 9'd1) begin
              progs_left_d = progs_after;
              cur_prog_d   = cur_prog_q + 8'd1;
              phase_d      = (progs_after == 8'd0) ? PH_DONE : PH_CNT_LO;
            end else begin
              phase_d = PH_TMR_LO;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  assign push_o = accept && !first_byte_i && (phase_q == PH_TMR_HI);
  assign push_item_o.program_index = cur_prog_q;
  assign push_item_o.timer_index   = cur_timer_q;
  assign push_item_o.word          = {data_byte_i, low_byte_q};
  assign push_item_o.blob_done     = (timers_left_q == 9'd1) && (progs_left_q == 8'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      hdr_pos_q     <= '0;
      progs_left_q  <= '0;
      cur_prog_q    <= '0;
      timers_left_q <= '0;
      cur_timer_q   <= '0;
      low_byte_q    <= '0;
    end else begin
      phase_q       <= phase_d;
      hdr_pos_q     <= hdr_pos_d;
      progs_left_q  <= progs_left_d;
      cur_prog_q    <= cur_prog_d;
      timers_left_q <= timers_left_d;
      cur_timer_q   <= cur_timer_d;
      low_byte_q    <= low_byte_d;
    end
  end

endmodule

>>> src/spbp_queue.sv
// Small FIFO of timer words between the byte walker and the decoder.
module spbp_queue #(
  parameter int unsigned Depth = spbp_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  spbp_pkg::word_item_t push_item_i,
  input  logic                 pop_i,
  output spbp_pkg::word_item_t pop_item_o,
  output logic                 empty_o,
  output logic                 full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  spbp_pkg::word_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == FullCnt);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> src/spbp_back.sv
// Timer word decoder: two register stages, minutes split into hour and minute.
module spbp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  spbp_pkg::word_item_t q_item_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output spbp_pkg::result_t    out_o
);

  typedef struct packed {
    logic [7:0]  program_index;
    logic [8:0]  timer_index;
    logic [2:0]  switch_state;
    logic        event_kind;
    logic        recognized;
    logic        is_clock;
    logic [10:0] minutes;
    logic [5:0]  hour_est;
    logic        sun_reference;
    logic [17:0] offset_seconds;
    logic        blob_done;
  } stage_a_t;

  stage_a_t a_q, a_d;
  logic     a_valid_q;
  logic     a_ready, b_ready;
  logic     out_valid_q;
  spbp_pkg::result_t out_q, out_d;

  logic [4:0]  code;
  logic [10:0] minutes;
  logic [8:0]  sun_units;
  logic [21:0] recip_prod;
  logic [16:0] clock_secs;
  logic [14:0] sun_secs;
  logic        is_clock, is_sun;
  logic [11:0] rem_est;
  logic [11:0] est_secs;

  assign b_ready = !out_valid_q || out_ready_i;
  assign a_ready = !a_valid_q || b_ready;
  assign q_pop_o = !q_empty_i && a_ready;

  assign code       = q_item_i.word[4:0];
  assign minutes    = q_item_i.word[15:5];
  assign sun_units  = q_item_i.word[15:7];
  assign is_clock   = (code == spbp_pkg::CODE_CLOCK_OFF) || (code == spbp_pkg::CODE_CLOCK_ON);
  assign is_sun     = (code == spbp_pkg::CODE_SUN_OFF) || (code == spbp_pkg::CODE_SUN_ON);
  assign recip_prod = {11'd0, minutes} * {11'd0, spbp_pkg::RECIP_60};
  assign clock_secs = {6'd0, minutes} * {11'd0, spbp_pkg::SECS_PER_MIN};
  assign sun_secs   = {6'd0, sun_units} * {9'd0, spbp_pkg::SECS_PER_MIN};

  always_comb begin
    a_d.program_index = q_item_i.program_index;
    a_d.timer_index   = q_item_i.timer_index;
    a_d.switch_state  = code[4:2];
    a_d.event_kind    = code[1];
    a_d.recognized    = is_clock || is_sun;
    a_d.is_clock      = is_clock;
    a_d.minutes       = minutes;
    // reciprocal estimate is exact or one low
    a_d.hour_est      = recip_prod[21:16];
    a_d.sun_reference = is_sun && q_item_i.word[5];
    a_d.blob_done     = q_item_i.blob_done;
    if (is_clock) begin
      a_d.offset_seconds = {1'b0, clock_secs};
    end else if (is_sun) begin
      a_d.offset_seconds = q_item_i.word[6] ? (18'd0 - {3'b000, sun_secs})
                                            : {3'b000, sun_secs};
    end else begin
      a_d.offset_seconds = '0;
    end
  end

  assign est_secs = {6'd0, a_q.hour_est} * {6'd0, spbp_pkg::SECS_PER_MIN};
  assign rem_est  = {1'b0, a_q.minutes} - est_secs;

  always_comb begin
    out_d.program_index  = a_q.program_index;
    out_d.timer_index    = a_q.timer_index;
    out_d.switch_state   = a_q.switch_state;
    out_d.event_kind     = a_q.event_kind;
    out_d.recognized     = a_q.recognized;
    out_d.sun_reference  = a_q.sun_reference;
    out_d.offset_seconds = a_q.offset_seconds;
    out_d.blob_done      = a_q.blob_done;
    out_d.hour           = '0;
    out_d.minute         = '0;
    if (a_q.is_clock) begin
      // fix up the one-low estimate
      if (rem_est >= 12'(spbp_pkg::SECS_PER_MIN)) begin
        out_d.hour   = a_q.hour_est + 6'd1;
        out_d.minute = 6'(rem_est - 12'(spbp_pkg::SECS_PER_MIN));
      end else begin
        out_d.hour   = a_q.hour_est;
        out_d.minute = rem_est[5:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      a_q <= a_d;
    end
    if (a_valid_q && b_ready) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= !q_empty_i;
      end
      if (b_ready) begin
        out_valid_q <= a_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> src/schedule_program_blob_parser_core.sv
// Top level of the schedule program blob parser.
//
//   channel  | dir | beat
//   ---------+-----+-----------------------------------------------------------
//   s_axis   | in  | one blob byte; tuser marks byte 0 of a blob
//   m_axis   | out | one decoded timer event; tlast marks the blob's final event
//
// One byte is taken per cycle; tready drops only when the word queue is full.
// After its high byte is taken, a timer event passes through the queue, the
// decode stage and the output register before it leaves.
// Reset clears all parse state and empties the queue; no pass runs after it.
// A stall on m_axis fills the queue and then holds s_axis.
module schedule_program_blob_parser_core #(
  parameter int unsigned QueueDepth = spbp_pkg::QUEUE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] data_byte
  input  logic [spbp_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [0] first_byte
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] program_index, [16:8] timer_index, [19:17] switch_state, [25:20] hour,
  // [31:26] minute, [32] sun_reference, [50:33] offset_seconds, [55:51] zero
  output logic [spbp_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // [0] event_kind, [1] recognized
  output logic [spbp_pkg::M_TUSER_W-1:0]   m_axis_tuser,
  // blob_done
  output logic                             m_axis_tlast
);

  spbp_pkg::word_item_t push_item, pop_item;
  spbp_pkg::result_t    result;
  logic push, pop, q_empty, q_full;

  assign s_axis_tready = !q_full;

  spbp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .data_byte_i  (s_axis_tdata),
    .first_byte_i (s_axis_tuser),
    .push_o       (push),
    .push_item_o  (push_item)
  );

  spbp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  spbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (pop_item),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (result)
  );

  assign m_axis_tdata = {5'b00000, result.offset_seconds, result.sun_reference,
                         result.minute, result.hour, result.switch_state,
                         result.timer_index, result.program_index};
  assign m_axis_tuser = {result.recognized, result.event_kind};
  assign m_axis_tlast = result.blob_done;

endmodule

>>> tb/tb_schedule_program_blob_parser_core.sv
// Self-checking stream testbench for the schedule program blob parser core.
module tb_schedule_program_blob_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET  = 1150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOUR_MINUTES = 60;

  typedef enum logic [2:0] {
    PARSE_IDLE,
    PARSE_HEADER,
    PARSE_COUNT_LO,
    PARSE_COUNT_HI,
    PARSE_WORD_LO,
    PARSE_WORD_HI,
    PARSE_DONE
  } parse_phase_e;

  typedef struct {
    logic [7:0]        data;
    logic              first;
    logic              typed;
    spbp_pkg::result_t want;
  } blob_beat_t;

  logic                           clk_i;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [spbp_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                           s_axis_tuser = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [spbp_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic [spbp_pkg::M_TUSER_W-1:0] m_axis_tuser;
  logic                           m_axis_tlast;

  schedule_program_blob_parser_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Parser shadow state
  parse_phase_e phase_q = PARSE_IDLE;
  logic [2:0]   hdr_pos = '0;
  logic [7:0]   progs_left = '0;
  logic [7:0]   prog_idx = '0;
  logic [8:0]   tmrs_left = '0;
  logic [8:0]   tmr_idx = '0;
  logic [7:0]   low_byte = '0;

  spbp_pkg::result_t pending_events[$];
  blob_beat_t        blob_beats[$];
  logic              beat_typed = 1'b0;
  spbp_pkg::result_t beat_want = '0;
  int                bytes_taken = 0;
  int                mismatches = 0;
  int                cycle_count = 0;
  int                send_idle_pct = 20;
  int                recv_stall_pct = 81;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void end_program();
    progs_left = progs_left - 8'd1;
    prog_idx   = prog_idx + 8'd1;
    phase_q    = (progs_left == 8'd0) ? PARSE_DONE : PARSE_COUNT_LO;
  endfunction

  function automatic spbp_pkg::result_t decode_timer_word(input logic [15:0] w);
    spbp_pkg::result_t ev;
    logic [4:0]        code;
    int unsigned       mins;
    int unsigned       mag;
    ev   = '0;
    code = w[4:0];
    ev.program_index = prog_idx;
    ev.timer_index   = tmr_idx;
    ev.switch_state  = code[4:2];
    ev.event_kind    = code[1];
    if (code == spbp_pkg::CODE_CLOCK_OFF || code == spbp_pkg::CODE_CLOCK_ON) begin
      mins = w[15:5];
      ev.recognized     = 1'b1;
      ev.hour           = 6'(mins / HOUR_MINUTES);
      ev.minute         = 6'(mins % HOUR_MINUTES);
      ev.offset_seconds = 18'(mins * spbp_pkg::SECS_PER_MIN);
    end else if (code == spbp_pkg::CODE_SUN_OFF || code == spbp_pkg::CODE_SUN_ON) begin
      mag = w[15:7];
      mag = mag * spbp_pkg::SECS_PER_MIN;
      ev.recognized     = 1'b1;
      ev.sun_reference  = w[5];
      ev.offset_seconds = w[6] ? 18'(0 - mag) : 18'(mag);
    end
    return ev;
  endfunction

  // Advance the shadow parser by one byte; return 1 when a timer event comes out.
  function automatic bit parse_byte(input logic [7:0] b, input logic first,
                                    output spbp_pkg::result_t ev);
    logic [15:0] w;
    ev = '0;
    if (first) begin
      hdr_pos    = 3'd1;
      progs_left = '0;
      prog_idx   = '0;
      tmrs_left  = '0;
      tmr_idx    = '0;
      low_byte   = '0;
      phase_q    = PARSE_HEADER;
      return 1'b0;
    end
    case (phase_q)
      PARSE_HEADER: begin
        if (hdr_pos == 3'd1) progs_left = b - 8'd1;
        if (hdr_pos >= 3'd6) begin
          hdr_pos = '0;
          phase_q = (progs_left == 8'd0) ? PARSE_DONE : PARSE_COUNT_LO;
        end else begin
          hdr_pos = hdr_pos + 3'd1;
        end
      end
      PARSE_COUNT_LO: begin
        low_byte = b;
        phase_q  = PARSE_COUNT_HI;
      end
      PARSE_COUNT_HI: begin
        w         = {b, low_byte};
        tmrs_left = w[15:7];
        tmr_idx   = '0;
        if (tmrs_left == 9'd0) end_program();
        else phase_q = PARSE_WORD_LO;
      end
      PARSE_WORD_LO: begin
        low_byte = b;
        phase_q  = PARSE_WORD_HI;
      end
      PARSE_WORD_HI: begin
        ev        = decode_timer_word({b, low_byte});
        tmr_idx   = tmr_idx + 9'd1;
        tmrs_left = tmrs_left - 9'd1;
        if (tmrs_left == 9'd0) begin
          end_program();
          ev.blob_done = (progs_left == 8'd0);
        end else begin
          phase_q = PARSE_WORD_LO;
        end
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic add_beat(input logic [7:0] data, input logic first,
                          input logic typed = 1'b0, input spbp_pkg::result_t want = '0);
    blob_beat_t beat;
    beat.data  = data;
    beat.first = first;
    beat.typed = typed;
    beat.want  = want;
    blob_beats.insert(blob_beats.size(), beat);
  endtask

  function automatic logic [15:0] random_timer_word();
    logic [4:0]  code;
    logic [10:0] upper;
    if ($urandom_range(9) < 7) begin
      case ($urandom_range(3))
        0:       code = spbp_pkg::CODE_CLOCK_OFF;
        1:       code = spbp_pkg::CODE_SUN_OFF;
        2:       code = spbp_pkg::CODE_CLOCK_ON;
        default: code = spbp_pkg::CODE_SUN_ON;
      endcase
    end else begin
      code = 5'($urandom);
    end
    case ($urandom_range(7))
      0:       upper = '1;
      1:       upper = '0;
      default: upper = 11'($urandom);
    endcase
    return {upper, code};
  endfunction

  // Build one blob; a wide one claims 255 programs and is cut off partway.
  task automatic gen_blob(input bit wide);
    blob_beat_t  blob[$];
    blob_beat_t  beat;
    int          n_prog;
    int          n_tmr;
    int          cut;
    logic [15:0] w;
    beat.typed = 1'b0;
    beat.want  = '0;
    n_prog = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 4);
    beat.first = 1'b1;
    beat.data  = 8'($urandom);
    blob.insert(blob.size(), beat);
    beat.first = 1'b0;
    beat.data  = wide ? 8'd0 : 8'(n_prog + 1);
    blob.insert(blob.size(), beat);
    repeat (5) begin
      beat.data = 8'($urandom);
      blob.insert(blob.size(), beat);
    end
    for (int p = 0; p < (wide ? 24 : n_prog); p++) begin
      if (wide) n_tmr = $urandom_range(0, 1);
      else if ($urandom_range(39) == 0) n_tmr = $urandom_range(20, 40);
      else n_tmr = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
      w = {9'(n_tmr), 7'($urandom)};
      beat.data = w[7:0];
      blob.insert(blob.size(), beat);
      beat.data = w[15:8];
      blob.insert(blob.size(), beat);
      for (int t = 0; t < n_tmr; t++) begin
        w = random_timer_word();
        beat.data = w[7:0];
        blob.insert(blob.size(), beat);
        beat.data = w[15:8];
        blob.insert(blob.size(), beat);
      end
    end
    if (wide || $urandom_range(9) == 0) begin
      // drop the tail; the next start mark abandons this blob
      cut  = $urandom_range(2, blob.size() - 1);
      blob = blob[0:cut-1];
    end else if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        beat.data = 8'($urandom);
        blob.insert(blob.size(), beat);
      end
    end
    foreach (blob[i]) blob_beats.insert(blob_beats.size(), blob[i]);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d events outstanding", $time, pending_events.size());
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    spbp_pkg::result_t got;
    spbp_pkg::result_t want;
    spbp_pkg::result_t ev;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.program_index  = m_axis_tdata[7:0];
        got.timer_index    = m_axis_tdata[16:8];
        got.switch_state   = m_axis_tdata[19:17];
        got.hour           = m_axis_tdata[25:20];
        got.minute         = m_axis_tdata[31:26];
        got.sun_reference  = m_axis_tdata[32];
        got.offset_seconds = m_axis_tdata[50:33];
        got.event_kind     = m_axis_tuser[0];
        got.recognized     = m_axis_tuser[1];
        got.blob_done      = m_axis_tlast;
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected event, expected none actual %h/%h/%b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatches++;
        end else begin
          want = pending_events.pop_front();
          check_field("program_index", want.program_index, got.program_index);
          check_field("timer_index", want.timer_index, got.timer_index);
          check_field("switch_state", want.switch_state, got.switch_state);
          check_field("event_kind", want.event_kind, got.event_kind);
          check_field("recognized", want.recognized, got.recognized);
          check_field("hour", want.hour, got.hour);
          check_field("minute", want.minute, got.minute);
          check_field("sun_reference", want.sun_reference, got.sun_reference);
          check_field("offset_seconds", want.offset_seconds, got.offset_seconds);
          check_field("blob_done", want.blob_done, got.blob_done);
          check_field("tdata padding", '0, m_axis_tdata[55:51]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (parse_byte(s_axis_tdata, s_axis_tuser, ev))
          pending_events.insert(pending_events.size(), beat_typed ? beat_want : ev);
        bytes_taken++;
      end
    end
  end

  initial begin
    spbp_pkg::result_t clock_max;
    spbp_pkg::result_t sun_max;
    int                third;
    int                target;
    bit                wide_done;

    // latest clock time: 2047 minutes
    clock_max = '{program_index: 8'd1, timer_index: 9'd0, switch_state: 3'd0,
                  event_kind: 1'b0, recognized: 1'b1, hour: 6'd34, minute: 6'd7,
                  sun_reference: 1'b0, offset_seconds: 18'd122820, blob_done: 1'b0};
    // sunrise, largest offset before it (-30660 s)
    sun_max   = '{program_index: 8'd1, timer_index: 9'd1, switch_state: 3'd1,
                  event_kind: 1'b1, recognized: 1'b1, hour: 6'd0, minute: 6'd0,
                  sun_reference: 1'b1, offset_seconds: 18'h3883C, blob_done: 1'b0};

    add_beat(8'hFF, 1'b0);                 // ignored, no blob started yet
    add_beat(8'h00, 1'b1);
    add_beat(8'h01, 1'b0);                 // no programs
    add_beat(8'hFF, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat(8'hAA, 1'b0);
    add_beat(8'h55, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'h77, 1'b0);                 // ignored after the blob ends
    add_beat(8'hFF, 1'b1);
    add_beat(8'h03, 1'b0);                 // two programs
    add_beat(8'h00, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'h5A, 1'b0);
    add_beat(8'hA5, 1'b0);
    add_beat(8'h80, 1'b0);
    add_beat(8'h7F, 1'b0);                 // program with no timers
    add_beat(8'h00, 1'b0);
    add_beat(8'h80, 1'b0);                 // three timers
    add_beat(8'h01, 1'b0);
    add_beat(8'hE1, 1'b0);
    add_beat(8'hFF, 1'b0, 1'b1, clock_max);
    add_beat(8'hE7, 1'b0);
    add_beat(8'hFF, 1'b0, 1'b1, sun_max);
    add_beat(8'hFE, 1'b0);
    add_beat(8'h00, 1'b1);                 // start mark in mid-word

    wide_done = 1'b0;
    while (blob_beats.size() < ITEM_TARGET) begin
      gen_blob(!wide_done && blob_beats.size() > 400);
      if (blob_beats.size() > 400) wide_done = 1'b1;
    end
    third = blob_beats.size() / 3;

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (blob_beats[i]) begin
      if (i == third) begin
        // swap the idle ratios, then hold off until the block has drained
        send_idle_pct  = 81;
        recv_stall_pct = 20;
        s_axis_tvalid <= 1'b0;
        do @(negedge clk_i); while (pending_events.size() != 0);
      end
      if (i == 2 * third) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= blob_beats[i].data;
      s_axis_tuser  <= blob_beats[i].first;
      beat_typed    <= blob_beats[i].typed;
      beat_want     <= blob_beats[i].want;
      target = bytes_taken + 1;
      do @(negedge clk_i); while (bytes_taken != target);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
